// File: hdl/snap_pkg.sv
package snap_pkg;

	localparam int COORD_BITS = 24;
	localparam int SLOT_BITS = 12;
	localparam int CNT_REG_BITS = 13;
	localparam int THR_BITS = 23;
	localparam int LIM_BITS = 2 * THR_BITS;
	localparam int D2_BITS = 2 * COORD_BITS + 2;
	localparam int VIDX_BITS = 13;

	localparam logic [THR_BITS-1:0] THR_RESET = 23'd512;

	localparam logic [1:0] CMD_LOAD_LEFT = 2'd0;
	localparam logic [1:0] CMD_LOAD_RIGHT = 2'd1;
	localparam logic [1:0] CMD_QUERY = 2'd2;

	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_FAR = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	localparam logic [1:0] REG_LEFT_COUNT = 2'd0;
	localparam logic [1:0] REG_RIGHT_COUNT = 2'd1;
	localparam logic [1:0] REG_THRESHOLD = 2'd2;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic signed [COORD_BITS-1:0] z;
	} vertex_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [SLOT_BITS-1:0] slot;
		logic signed [COORD_BITS-1:0] first_x;
		logic signed [COORD_BITS-1:0] first_y;
		logic signed [COORD_BITS-1:0] first_z;
		logic signed [COORD_BITS-1:0] second_x;
		logic signed [COORD_BITS-1:0] second_y;
		logic signed [COORD_BITS-1:0] second_z;
	} item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [VIDX_BITS-1:0] start_vertex;
		logic [VIDX_BITS-1:0] end_vertex;
	} result_t;

endpackage

// File: hdl/segment_endpoint_nearest_vertex_snap_core.sv
// Channel   Direction  Handshake                   Payload
// item      in         item_valid / item_ready     snap_pkg::item_t
// result    out        result_valid / result_ready snap_pkg::result_t
// apb       in/out     psel & penable & pwrite     pwdata -> reg paddr[3:2]
//
// Loads write their table on acceptance. A query scans N = max(left, right)
// effective count entries: one read port per table, one vertex per cycle
// through a three-stage distance pipeline, once per endpoint; none if empty.
// item_ready is high only while idle; a pending result does not block loads.
// Reset clears counts, sets threshold to 2.0; vertex tables are not cleared.
module segment_endpoint_nearest_vertex_snap_core #(
	parameter int MAX_VERTICES = 4096
) (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [3:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input logic item_valid,
	output logic item_ready,
	input snap_pkg::item_t item,
	output logic result_valid,
	input logic result_ready,
	output snap_pkg::result_t result
);
	import snap_pkg::*;

	localparam int IDX_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int EW = (CNT_W > CNT_REG_BITS) ? CNT_W : CNT_REG_BITS;
	localparam int CMPW = (CNT_W > SLOT_BITS) ? CNT_W : SLOT_BITS;
	localparam int VW = $bits(vertex_t);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_RESOLVE = 3'd3;
	localparam logic [2:0] ST_FINISH = 3'd4;

	// drain counter value on which the drain ends; the best trackers are final in ST_RESOLVE
	localparam logic [1:0] DRAIN_LAST = 2'd3;

	// configuration
	logic [CNT_REG_BITS-1:0] left_count_q, right_count_q;
	logic [THR_BITS-1:0] thr_q;
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_count_q <= '0;
			right_count_q <= '0;
			thr_q <= THR_RESET;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_LEFT_COUNT: left_count_q <= pwdata[CNT_REG_BITS-1:0];
				REG_RIGHT_COUNT: right_count_q <= pwdata[CNT_REG_BITS-1:0];
				REG_THRESHOLD: thr_q <= pwdata[THR_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_LEFT_COUNT: prdata = 32'(left_count_q);
			REG_RIGHT_COUNT: prdata = 32'(right_count_q);
			REG_THRESHOLD: prdata = 32'(thr_q);
			default: prdata = 32'd0;
		endcase
	end

	// effective counts, saturated to table depth
	logic [EW-1:0] lc_ext, rc_ext;
	logic [CNT_W-1:0] nl, nr, scan_n;

	assign lc_ext = EW'(left_count_q);
	assign rc_ext = EW'(right_count_q);
	assign nl = (lc_ext > EW'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : CNT_W'(lc_ext);
	assign nr = (rc_ext > EW'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : CNT_W'(rc_ext);
	assign scan_n = (nl > nr) ? nl : nr;

	// sequencer
	logic [2:0] state_q;
	logic ep_q;
	logic [CNT_W-1:0] i_q;
	logic [1:0] drain_q;
	logic empty_q;
	vertex_t p_first_q, p_second_q;
	logic [LIM_BITS-1:0] lim_q;
	logic [VIDX_BITS-1:0] s_idx_q, e_idx_q;
	logic [D2_BITS-1:0] s_d2_q, e_d2_q;
	logic result_valid_q;
	result_t result_q;
	logic finish_go;

	logic item_acc, is_query, is_load_l, is_load_r;
	logic [CMPW-1:0] slot_ext;
	logic slot_ok;

	assign item_ready = (state_q == ST_IDLE);
	assign item_acc = item_valid && item_ready;
	assign is_query = (item.cmd == CMD_QUERY);
	assign is_load_l = (item.cmd == CMD_LOAD_LEFT);
	assign is_load_r = (item.cmd == CMD_LOAD_RIGHT);
	assign slot_ext = CMPW'(item.slot);
	assign slot_ok = slot_ext < CMPW'(MAX_VERTICES);
	assign finish_go = (state_q == ST_FINISH) && (!result_valid_q || result_ready);

	// tables
	vertex_t load_v, rdata_l, rdata_r;
	logic [IDX_W-1:0] waddr, raddr;
	logic [VW-1:0] rd_l_raw, rd_r_raw;

	assign load_v = '{x: item.first_x, y: item.first_y, z: item.first_z};
	assign waddr = slot_ext[IDX_W-1:0];
	assign raddr = i_q[IDX_W-1:0];
	assign rdata_l = vertex_t'(rd_l_raw);
	assign rdata_r = vertex_t'(rd_r_raw);

	snap_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_left_ram (
		.clk(clk),
		.we(item_acc && is_load_l && slot_ok),
		.waddr(waddr),
		.wdata(load_v),
		.raddr(raddr),
		.rdata(rd_l_raw)
	);

	snap_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_right_ram (
		.clk(clk),
		.we(item_acc && is_load_r && slot_ok),
		.waddr(waddr),
		.wdata(load_v),
		.raddr(raddr),
		.rdata(rd_r_raw)
	);

	// tags aligned with the registered read data
	logic tag_l_s1, tag_r_s1;
	logic [IDX_W-1:0] tag_idx_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_l_s1 <= 1'b0;
			tag_r_s1 <= 1'b0;
		end else begin
			tag_l_s1 <= (state_q == ST_SCAN) && (i_q < nl);
			tag_r_s1 <= (state_q == ST_SCAN) && (i_q < nr);
		end
	end

	always_ff @(posedge clk) begin
		tag_idx_s1 <= i_q[IDX_W-1:0];
	end

	vertex_t point;
	assign point = ep_q ? p_second_q : p_first_q;

	logic dl_valid, dr_valid;
	logic [IDX_W-1:0] dl_idx, dr_idx;
	logic [D2_BITS-1:0] dl_d2, dr_d2;

	snap_dist #(.IDX_W(IDX_W)) u_dist_left (
		.clk(clk), .arst_n(arst_n),
		.src_valid(tag_l_s1), .src_idx(tag_idx_s1),
		.point(point), .vert(rdata_l),
		.dst_valid(dl_valid), .dst_idx(dl_idx), .d2(dl_d2)
	);

	snap_dist #(.IDX_W(IDX_W)) u_dist_right (
		.clk(clk), .arst_n(arst_n),
		.src_valid(tag_r_s1), .src_idx(tag_idx_s1),
		.point(point), .vert(rdata_r),
		.dst_valid(dr_valid), .dst_idx(dr_idx), .d2(dr_d2)
	);

	logic best_clear;
	logic bl_found, br_found;
	logic [IDX_W-1:0] bl_idx, br_idx;
	logic [D2_BITS-1:0] bl_d2, br_d2;

	assign best_clear = (state_q == ST_IDLE) || ((state_q == ST_RESOLVE) && !ep_q);

	snap_best #(.IDX_W(IDX_W)) u_best_left (
		.clk(clk), .arst_n(arst_n), .clear(best_clear),
		.valid(dl_valid), .idx(dl_idx), .d2(dl_d2),
		.found(bl_found), .best_idx(bl_idx), .best_d2(bl_d2)
	);

	snap_best #(.IDX_W(IDX_W)) u_best_right (
		.clk(clk), .arst_n(arst_n), .clear(best_clear),
		.valid(dr_valid), .idx(dr_idx), .d2(dr_d2),
		.found(br_found), .best_idx(br_idx), .best_d2(br_d2)
	);

	// left wins only when strictly closer; right indices follow the left ones
	logic take_left;
	logic [CNT_W:0] right_merged;
	logic [VIDX_BITS-1:0] merged;
	logic [D2_BITS-1:0] d2_sel;
	logic start_ok, end_ok;

	assign take_left = bl_found && (!br_found || (bl_d2 < br_d2));
	assign right_merged = (CNT_W + 1)'(br_idx) + (CNT_W + 1)'(nl);
	assign merged = take_left ? VIDX_BITS'(bl_idx) : VIDX_BITS'(right_merged);
	assign d2_sel = take_left ? bl_d2 : br_d2;
	assign start_ok = s_d2_q < D2_BITS'(lim_q);
	assign end_ok = e_d2_q < D2_BITS'(lim_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (finish_go) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ep_q <= 1'b0;
			i_q <= '0;
			drain_q <= '0;
			empty_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (item_acc && is_query) begin
						ep_q <= 1'b0;
						i_q <= '0;
						if ((nl == '0) && (nr == '0)) begin
							empty_q <= 1'b1;
							state_q <= ST_FINISH;
						end else begin
							empty_q <= 1'b0;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					i_q <= i_q + CNT_W'(1);
					if (i_q == scan_n - CNT_W'(1)) begin
						drain_q <= '0;
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (drain_q == DRAIN_LAST) begin
						state_q <= ST_RESOLVE;
					end else begin
						drain_q <= drain_q + 2'd1;
					end
				end
				ST_RESOLVE: begin
					if (!ep_q) begin
						ep_q <= 1'b1;
						i_q <= '0;
						state_q <= ST_SCAN;
					end else begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (finish_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc && is_query) begin
			p_first_q <= '{x: item.first_x, y: item.first_y, z: item.first_z};
			p_second_q <= '{x: item.second_x, y: item.second_y, z: item.second_z};
			lim_q <= thr_q * thr_q;
		end
		if (state_q == ST_RESOLVE) begin
			if (!ep_q) begin
				s_idx_q <= merged;
				s_d2_q <= d2_sel;
			end else begin
				e_idx_q <= merged;
				e_d2_q <= d2_sel;
			end
		end
		if (finish_go) begin
			if (empty_q) begin
				result_q <= '{status: STAT_EMPTY, start_vertex: '0, end_vertex: '0};
			end else if (start_ok && end_ok) begin
				result_q <= '{status: STAT_OK, start_vertex: s_idx_q, end_vertex: e_idx_q};
			end else begin
				result_q <= '{status: STAT_FAR, start_vertex: '0, end_vertex: '0};
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

endmodule

// File: hdl/snap_ram.sv
module snap_ram #(
	parameter int WIDTH = 72,
	parameter int DEPTH = 4096
) (
	input logic clk,
	input logic we,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hdl/snap_dist.sv
// Three-stage squared distance: |diff| per axis, squares, sum.
module snap_dist #(
	parameter int IDX_W = 12
) (
	input logic clk,
	input logic arst_n,
	input logic src_valid,
	input logic [IDX_W-1:0] src_idx,
	input snap_pkg::vertex_t point,
	input snap_pkg::vertex_t vert,
	output logic dst_valid,
	output logic [IDX_W-1:0] dst_idx,
	output logic [snap_pkg::D2_BITS-1:0] d2
);
	import snap_pkg::*;

	localparam int SQ_W = 2 * COORD_BITS;

	function automatic logic [COORD_BITS-1:0] abs_diff(
		input logic signed [COORD_BITS-1:0] a,
		input logic signed [COORD_BITS-1:0] b
	);
		logic signed [COORD_BITS:0] d;
		d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
		return d[COORD_BITS] ? COORD_BITS'(-d) : COORD_BITS'(d);
	endfunction

	logic v_s1, v_s2, v_s3;
	logic [IDX_W-1:0] idx_s1, idx_s2, idx_s3;
	logic [COORD_BITS-1:0] ax_s1, ay_s1, az_s1;
	logic [SQ_W-1:0] sx_s2, sy_s2, sz_s2;
	logic [D2_BITS-1:0] d2_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= src_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= src_idx;
		ax_s1 <= abs_diff(point.x, vert.x);
		ay_s1 <= abs_diff(point.y, vert.y);
		az_s1 <= abs_diff(point.z, vert.z);
		idx_s2 <= idx_s1;
		sx_s2 <= ax_s1 * ax_s1;
		sy_s2 <= ay_s1 * ay_s1;
		sz_s2 <= az_s1 * az_s1;
		idx_s3 <= idx_s2;
		d2_s3 <= D2_BITS'(sx_s2) + D2_BITS'(sy_s2) + D2_BITS'(sz_s2);
	end

	assign dst_valid = v_s3;
	assign dst_idx = idx_s3;
	assign d2 = d2_s3;

endmodule

// File: hdl/snap_best.sv
// Running minimum of one table; first strictly smaller distance wins.
module snap_best #(
	parameter int IDX_W = 12
) (
	input logic clk,
	input logic arst_n,
	input logic clear,
	input logic valid,
	input logic [IDX_W-1:0] idx,
	input logic [snap_pkg::D2_BITS-1:0] d2,
	output logic found,
	output logic [IDX_W-1:0] best_idx,
	output logic [snap_pkg::D2_BITS-1:0] best_d2
);
	import snap_pkg::*;

	logic found_q;
	logic [IDX_W-1:0] idx_q;
	logic [D2_BITS-1:0] d2_q;
	logic take;

	assign take = valid && (!found_q || (d2 < d2_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (clear) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			idx_q <= idx;
			d2_q <= d2;
		end
	end

	assign found = found_q;
	assign best_idx = idx_q;
	assign best_d2 = d2_q;

endmodule

// File: hdl/snap_checker.sv
module snap_checker (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input logic item_ready,
	input snap_pkg::item_t item,
	input logic result_valid,
	input logic result_ready,
	input snap_pkg::result_t result
);
	import snap_pkg::*;

	// a pending result transaction holds its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// item_ready is low in the cycle after a query is accepted
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && (item.cmd == CMD_QUERY) |=> !item_ready)
		else $error("ready right after a query");

	// after a load or other non-query item, item_ready is high in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && (item.cmd != CMD_QUERY) |=> item_ready)
		else $error("load stalled the input");

	// rejected or empty results carry zero indices
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status != STAT_OK)
		|-> (result.start_vertex == '0) && (result.end_vertex == '0))
		else $error("nonzero index on a rejection");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.status == STAT_OK) || (result.status == STAT_FAR)
		|| (result.status == STAT_EMPTY))
		else $error("undefined status code");

endmodule

bind segment_endpoint_nearest_vertex_snap_core snap_checker u_snap_checker (
	.clk(clk),
	.arst_n(arst_n),
	.item_valid(item_valid),
	.item_ready(item_ready),
	.item(item),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.result(result)
);
